// File: src/aard_pkg.sv
// Shared types and constants for the alpha atlas run-length decoder.
`default_nettype none
package aard_pkg;

    // Width of the pixel counters and of the image size register
    localparam int COUNT_BITS = 24;

    // Token fields
    localparam logic [7:0] TOK_LEN_MASK = 8'h7f;
    localparam logic [7:0] TOK_LIT_BIT  = 8'h80;

    // Status codes
    localparam logic [1:0] ST_RUNNING  = 2'd0;
    localparam logic [1:0] ST_OK       = 2'd1;
    localparam logic [1:0] ST_OVERRUN  = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] run_length;
        logic       run_end;
        logic [1:0] status;
    } t_result;

    // 4-bit alpha scaled by 17 is the nibble repeated
    function automatic logic [7:0] scale_nibble(input logic [3:0] nib);
        return {nib, nib};
    endfunction

endpackage
`default_nettype wire

// File: src/aard_if.sv
// Valid/ready channel interfaces for payload bytes and decoded results.
`default_nettype none
interface aard_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output payload_byte, output first_byte,
                    output last_byte, input ready);
    modport sink   (input valid, input payload_byte, input first_byte,
                    input last_byte, output ready);
endinterface

interface aard_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] alpha;
    logic [7:0] run_length;
    logic       run_end;
    logic [1:0] status;

    modport source (output valid, output alpha, output run_length,
                    output run_end, output status, input ready);
    modport sink   (input valid, input alpha, input run_length,
                    input run_end, input status, output ready);
endinterface
`default_nettype wire

// File: src/alpha_atlas_rle_decoder.sv
// The first result of a byte is registered and on the output in the cycle after its transfer.
// Throughput: one byte per cycle while the output is not stalled; a literal byte holding
// two pixels occupies the single result port until both are taken, so the next byte waits.
// Bytes that give no result (a literal token, or any byte after an error) pass at one per cycle.
// Reset (i_rst_n low, synchronous): decode state cleared and result queue emptied,
// r_total set to 1.
`default_nettype none
module alpha_atlas_rle_decoder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [aard_pkg::COUNT_BITS-1:0]       i_cfg_wdata,
    aard_in_if.sink                              i_in,
    aard_out_if.source                           o_out
);

    localparam int CW = aard_pkg::COUNT_BITS;

    // Configuration and decode state
    logic [CW-1:0] r_total;
    logic          r_lit;
    logic [7:0]    r_left;
    logic [CW-1:0] r_emit;
    logic [1:0]    r_err;

    logic          n_lit;
    logic [7:0]    n_left;
    logic [CW-1:0] n_emit;
    logic [1:0]    n_err;

    // Two-entry result queue
    aard_pkg::t_result r_res0, r_res1, n_res0, n_res1;
    logic [1:0]        r_cnt, n_cnt;

    // Results of the byte being transferred
    aard_pkg::t_result d_res0, d_res1;
    logic [1:0]        d_num;

    logic out_fire, in_fire;

    assign o_out.valid      = (r_cnt != 2'd0);
    assign o_out.alpha      = r_res0.alpha;
    assign o_out.run_length = r_res0.run_length;
    assign o_out.run_end    = r_res0.run_end;
    assign o_out.status     = r_res0.status;

    assign out_fire   = o_out.valid && o_out.ready;
    // Accept when the queue is empty after this cycle's pop
    assign i_in.ready = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;

    // Byte decode
    always_comb begin
        logic          c_lit;
        logic [7:0]    c_left;
        logic [CW-1:0] c_emit;
        logic [1:0]    c_err;
        logic [7:0]    b;
        logic [7:0]    len;
        logic [CW-1:0] free;
        logic [1:0]    fs;

        b      = i_in.payload_byte;
        c_lit  = i_in.first_byte ? 1'b0 : r_lit;
        c_left = i_in.first_byte ? 8'd0 : r_left;
        c_emit = i_in.first_byte ? '0 : r_emit;
        c_err  = i_in.first_byte ? aard_pkg::ST_RUNNING : r_err;
        len    = (b & aard_pkg::TOK_LEN_MASK) + 8'd1;
        free   = r_total - c_emit;
        fs     = aard_pkg::ST_RUNNING;

        d_res0 = '0;
        d_res1 = '0;
        d_num  = 2'd0;

        if (c_err == aard_pkg::ST_RUNNING) begin
            if (c_lit && (c_left != 8'd0)) begin
                // Literal pair, high nibble first
                d_res0.alpha      = aard_pkg::scale_nibble(b[7:4]);
                d_res0.run_length = 8'd1;
                d_num             = 2'd1;
                c_emit            = c_emit + CW'(1);
                c_left            = c_left - 8'd1;
                if (c_left != 8'd0) begin
                    d_res1.alpha      = aard_pkg::scale_nibble(b[3:0]);
                    d_res1.run_length = 8'd1;
                    d_num             = 2'd2;
                    c_emit            = c_emit + CW'(1);
                    c_left            = c_left - 8'd1;
                end
                if (c_left == 8'd0) begin
                    c_lit = 1'b0;
                end
            end else begin
                // Token
                c_lit = 1'b0;
                if (c_emit >= r_total) begin
                    c_err = aard_pkg::ST_MISMATCH;
                end else if (CW'(len) > free) begin
                    c_err = aard_pkg::ST_OVERRUN;
                end else if ((b & aard_pkg::TOK_LIT_BIT) == 8'd0) begin
                    d_res0.alpha      = 8'd0;
                    d_res0.run_length = len;
                    d_num             = 2'd1;
                    c_emit            = c_emit + CW'(len);
                end else begin
                    c_lit  = 1'b1;
                    c_left = len;
                end
            end
        end

        // End-of-payload check
        if (i_in.last_byte) begin
            if (c_err != aard_pkg::ST_RUNNING) begin
                fs = c_err;
            end else if (c_lit || (c_emit != r_total)) begin
                fs = aard_pkg::ST_MISMATCH;
            end else begin
                fs = aard_pkg::ST_OK;
            end
            if (d_num == 2'd0) begin
                d_num = 2'd1;
            end
            if (d_num == 2'd2) begin
                d_res1.status = fs;
            end else begin
                d_res0.status = fs;
            end
            c_lit  = 1'b0;
            c_left = 8'd0;
            c_emit = '0;
            c_err  = aard_pkg::ST_RUNNING;
        end

        // Mark the last result of this byte
        if (d_num == 2'd2) begin
            d_res1.run_end = 1'b1;
        end else begin
            d_res0.run_end = 1'b1;
        end

        n_lit  = c_lit;
        n_left = c_left;
        n_emit = c_emit;
        n_err  = c_err;
    end

    // Queue update
    always_comb begin
        n_res0 = out_fire ? r_res1 : r_res0;
        n_res1 = r_res1;
        n_cnt  = r_cnt - {1'b0, out_fire};
        if (in_fire) begin
            n_res0 = d_res0;
            n_res1 = d_res1;
            n_cnt  = d_num;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= CW'(1);
            r_lit   <= 1'b0;
            r_left  <= 8'd0;
            r_emit  <= '0;
            r_err   <= aard_pkg::ST_RUNNING;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (in_fire) begin
                r_lit  <= n_lit;
                r_left <= n_left;
                r_emit <= n_emit;
                r_err  <= n_err;
            end
            r_cnt <= n_cnt;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res0 <= n_res0;
        r_res1 <= n_res1;
    end

endmodule
`default_nettype wire

// File: src/aard_checker.sv
// Port-level assertions for the alpha atlas run-length decoder, with bind.
`default_nettype none
module aard_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_alpha,
    input wire [7:0] i_run_length,
    input wire       i_run_end,
    input wire [1:0] i_status
);

    // Status only on the last result of a byte
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != aard_pkg::ST_RUNNING)) |-> i_run_end)
        else $error("status on a result that is not the last of its byte");

    // Status-only results carry a status and alpha 0
    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_run_length == 8'd0)) |->
        ((i_status != aard_pkg::ST_RUNNING) && (i_alpha == 8'd0)))
        else $error("empty result without status");

    // Every alpha is a scaled 4-bit value
    a_alpha_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_alpha[7:4] == i_alpha[3:0]))
        else $error("alpha is not a scaled nibble");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_alpha) && $stable(i_run_length)
         && $stable(i_run_end) && $stable(i_status)))
        else $error("stalled result changed");

endmodule

bind alpha_atlas_rle_decoder aard_checker u_aard_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_alpha      (o_out.alpha),
    .i_run_length (o_out.run_length),
    .i_run_end    (o_out.run_end),
    .i_status     (o_out.status)
);
`default_nettype wire
